>>> rtl/core/pdf_pkg.sv
// ----------------------------------------------------------------------------
// pdf_pkg
// shared types and constants of the packet duplicate filter
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int HASH_W      = 32;
    localparam int TIME_W      = 48;
    localparam int TTL_W       = 16;
    localparam int TTL_US_W    = 26;
    localparam int CNT_W       = 32;
    localparam int ACTIVE_W    = 17;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

    localparam int US_PER_MS    = 1000;
    localparam int TTL_MS_RESET = 5000;
    localparam logic [TTL_US_W-1:0] TTL_US_RESET = TTL_US_W'(TTL_MS_RESET * US_PER_MS);

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_SWEEP = 1'b1;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_SWEEP   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_SWEEP,
        ST_SWEEP_DONE
    } t_state;

    typedef struct packed {
        logic              vld;
        logic [HASH_W-1:0] hash;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic hash_step;
        logic pkt_end;
        logic sweep_start;
        logic clr_step;
        logic lookup;
        logic decide;
        logic sweep_step;
        logic sweep_report;
    } t_dp_cmd;

    typedef struct packed {
        logic addr_last;
        logic sweep_pend;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/core/packet_dedupe_filter.sv
// ----------------------------------------------------------------------------
// packet_dedupe_filter
// duplicate packet filter, FNV-1a hash into a direct-mapped table with TTL
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_stall): one beat is a packet byte or a
// sweep command, with a microsecond timestamp
// output channel (o_out_valid / i_out_stall): one beat per packet verdict or
// sweep report, held in an output register while the receiver stalls
// config channel (i_cfg_valid / o_cfg_ready): ttl in milliseconds, always
// ready; to be written by the user only while the block is idle (not enforced)
// TABLE_DEPTH is to be a power of two (not checked), the table index is the
// low hash bits; a byte that is not last is hashed and gives no beat
// a last byte is hashed, then its table entry is read, then compared and,
// unless a duplicate, written as its verdict loads into the output register
// a sweep takes the beat, then reads one table entry per cycle on the read
// port while expired entries are invalidated through the write port, then
// finishes the last entry and loads the report
// non-last bytes are still taken while a finished result waits in the output
// register; a verdict or report waits until that register is free
// after reset every table entry is cleared with the input stalled; config
// writes are taken during the clearing pass
// ----------------------------------------------------------------------------
module packet_dedupe_filter #(
    parameter int TABLE_DEPTH = 1024,
    parameter int HASH_BYTES  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pdf_pkg::TTL_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    input  logic [pdf_pkg::TIME_W-1:0]      i_now_us,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_result_kind,
    output logic                            o_is_duplicate,
    output logic [pdf_pkg::HASH_W-1:0]      o_packet_hash,
    output logic [pdf_pkg::CNT_W-1:0]       o_forwarded_count,
    output logic [pdf_pkg::CNT_W-1:0]       o_dropped_count,
    output logic [pdf_pkg::ACTIVE_W-1:0]    o_active_flows
);
    import pdf_pkg::*;

    logic [TTL_US_W-1:0] r_ttl_us;
    t_dp_cmd             cmd;
    t_dp_sts             sts;

    assign o_cfg_ready = 1'b1;

    // ttl kept in microseconds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl_us <= TTL_US_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ttl_us <= TTL_US_W'(i_cfg_data * US_PER_MS);
        end
    end

    pdf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_last_byte (i_last_byte),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    pdf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HASH_BYTES  (HASH_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_ttl_us          (r_ttl_us),
        .i_data_byte       (i_data_byte),
        .i_now_us          (i_now_us),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_result_kind     (o_result_kind),
        .o_is_duplicate    (o_is_duplicate),
        .o_packet_hash     (o_packet_hash),
        .o_forwarded_count (o_forwarded_count),
        .o_dropped_count   (o_dropped_count),
        .o_active_flows    (o_active_flows)
    );

endmodule

>>> rtl/core/pdf_ctrl.sv
// ----------------------------------------------------------------------------
// pdf_ctrl
// sequencer for byte hashing, table lookup, sweep and clearing pass
// ----------------------------------------------------------------------------
module pdf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_command,
    input  logic             i_last_byte,
    input  pdf_pkg::t_dp_sts i_sts,
    output logic             o_in_stall,
    output pdf_pkg::t_dp_cmd o_cmd
);
    import pdf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   acc;

    assign acc = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.addr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc && i_command == CMD_SWEEP) n_state = ST_SWEEP;
                else if (acc && i_last_byte) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            ST_SWEEP: begin
                if (i_sts.addr_last) n_state = ST_SWEEP_DONE;
            end
            ST_SWEEP_DONE: begin
                if (!i_sts.sweep_pend && i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_stall         = (r_state != ST_IDLE);
        o_cmd              = '0;
        o_cmd.hash_step    = acc && (i_command == CMD_BYTE);
        o_cmd.pkt_end      = acc && (i_command == CMD_BYTE) && i_last_byte;
        o_cmd.sweep_start  = acc && (i_command == CMD_SWEEP);
        o_cmd.clr_step     = (r_state == ST_CLEAR);
        o_cmd.lookup       = (r_state == ST_LOOKUP);
        o_cmd.decide       = (r_state == ST_DECIDE) && i_sts.out_free;
        o_cmd.sweep_step   = (r_state == ST_SWEEP);
        o_cmd.sweep_report = (r_state == ST_SWEEP_DONE) && !i_sts.sweep_pend
                             && i_sts.out_free;
    end

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.decide || o_cmd.sweep_report) |-> i_sts.out_free)
        else $error("result loaded without a free output slot");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (o_in_stall && !o_cmd.hash_step && !o_cmd.sweep_start))
        else $error("input accepted during clearing pass");

endmodule

>>> rtl/core/pdf_dp.sv
// ----------------------------------------------------------------------------
// pdf_dp
// hash, flow table memory, counters and output register
// ----------------------------------------------------------------------------
module pdf_dp #(
    parameter int TABLE_DEPTH = 1024,
    parameter int HASH_BYTES  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pdf_pkg::t_dp_cmd                i_cmd,
    output pdf_pkg::t_dp_sts                o_sts,
    input  logic [pdf_pkg::TTL_US_W-1:0]    i_ttl_us,
    input  logic [7:0]                      i_data_byte,
    input  logic [pdf_pkg::TIME_W-1:0]      i_now_us,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic                            o_result_kind,
    output logic                            o_is_duplicate,
    output logic [pdf_pkg::HASH_W-1:0]      o_packet_hash,
    output logic [pdf_pkg::CNT_W-1:0]       o_forwarded_count,
    output logic [pdf_pkg::CNT_W-1:0]       o_dropped_count,
    output logic [pdf_pkg::ACTIVE_W-1:0]    o_active_flows
);
    import pdf_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int HC_W  = $clog2(HASH_BYTES + 1);

    // hash accumulation
    logic [HASH_W-1:0] r_hash;
    logic [HC_W-1:0]   r_hcnt;
    logic [HASH_W-1:0] n_hash_upd;

    // time threshold latched with the beat
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_thr;
    logic              r_thr_ok;
    logic              r_ttl_nz;
    logic [TIME_W:0]   thr_diff;

    // table index
    logic [IDX_W-1:0]  idx;

    // table
    t_entry            mem [TABLE_DEPTH];
    t_entry            r_rd;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic [IDX_W-1:0]  r_addr;
    logic [IDX_W-1:0]  r_sw_idx;
    logic              r_sw_pend;
    logic [ACTIVE_W-1:0] r_active;
    logic              expire;
    logic              keep;
    logic              dup;

    // statistics and output
    logic [CNT_W-1:0]  r_fwd;
    logic [CNT_W-1:0]  r_drop;
    logic [CNT_W-1:0]  n_fwd;
    logic [CNT_W-1:0]  n_drop;
    logic              load;
    logic              r_out_valid;
    logic              r_kind;
    logic              r_dup;
    logic [HASH_W-1:0] r_out_hash;
    logic [CNT_W-1:0]  r_out_fwd;
    logic [CNT_W-1:0]  r_out_drop;
    logic [ACTIVE_W-1:0] r_out_active;

    assign n_hash_upd = HASH_W'((r_hash ^ HASH_W'(i_data_byte)) * FNV_PRIME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
            r_hcnt <= '0;
        end else if (i_cmd.decide) begin
            r_hash <= FNV_BASIS;
            r_hcnt <= '0;
        end else if (i_cmd.hash_step && (r_hcnt < HC_W'(HASH_BYTES))) begin
            r_hash <= n_hash_upd;
            r_hcnt <= r_hcnt + 1'b1;
        end
    end

    assign thr_diff = {1'b0, i_now_us} - (TIME_W + 1)'(i_ttl_us);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pkt_end || i_cmd.sweep_start) begin
            r_now    <= i_now_us;
            r_thr    <= thr_diff[TIME_W-1:0];
            r_thr_ok <= !thr_diff[TIME_W];
            r_ttl_nz <= (i_ttl_us != '0);
        end
    end

    // power of two depth, index is the low hash bits
    assign idx = r_hash[IDX_W-1:0];

    // table walk address for clearing and sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.sweep_start) begin
            r_addr <= '0;
        end else if (i_cmd.clr_step || i_cmd.sweep_step) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_pend <= 1'b0;
        end else begin
            r_sw_pend <= i_cmd.sweep_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_step) begin
            r_sw_idx <= r_addr;
        end
    end

    assign rd_en   = i_cmd.lookup || i_cmd.sweep_step;
    assign rd_addr = i_cmd.lookup ? idx : r_addr;

    assign expire = r_sw_pend && r_rd.vld && r_thr_ok && (r_rd.stamp < r_thr);
    assign keep   = r_sw_pend && r_rd.vld && !expire;
    assign dup    = r_rd.vld && (r_rd.hash == r_hash) && r_ttl_nz
                    && (!r_thr_ok || (r_rd.stamp > r_thr));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = '0;
        priority if (i_cmd.clr_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.decide && !dup) begin
            wr_en         = 1'b1;
            wr_addr       = idx;
            wr_data.vld   = 1'b1;
            wr_data.hash  = r_hash;
            wr_data.stamp = r_now;
        end else if (expire) begin
            wr_en       = 1'b1;
            wr_addr     = r_sw_idx;
            wr_data     = r_rd;
            wr_data.vld = 1'b0;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.sweep_start) begin
            r_active <= '0;
        end else if (keep) begin
            r_active <= r_active + 1'b1;
        end
    end

    // saturating statistics
    always_comb begin
        n_fwd  = r_fwd;
        n_drop = r_drop;
        if (i_cmd.decide) begin
            if (dup) begin
                n_drop = (&r_drop) ? r_drop : r_drop + 1'b1;
            end else begin
                n_fwd = (&r_fwd) ? r_fwd : r_fwd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd  <= '0;
            r_drop <= '0;
        end else begin
            r_fwd  <= n_fwd;
            r_drop <= n_drop;
        end
    end

    // output register
    assign load = i_cmd.decide || i_cmd.sweep_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_kind       <= KIND_VERDICT;
            r_dup        <= dup;
            r_out_hash   <= r_hash;
            r_out_fwd    <= n_fwd;
            r_out_drop   <= n_drop;
            r_out_active <= '0;
        end else if (i_cmd.sweep_report) begin
            r_kind       <= KIND_SWEEP;
            r_dup        <= 1'b0;
            r_out_hash   <= '0;
            r_out_fwd    <= r_fwd;
            r_out_drop   <= r_drop;
            r_out_active <= r_active;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_kind;
    assign o_is_duplicate    = r_dup;
    assign o_packet_hash     = r_out_hash;
    assign o_forwarded_count = r_out_fwd;
    assign o_dropped_count   = r_out_drop;
    assign o_active_flows    = r_out_active;

    assign o_sts.addr_last  = (r_addr == IDX_W'(TABLE_DEPTH - 1));
    assign o_sts.sweep_pend = r_sw_pend;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !load)
        else $error("held result overwritten");

    a_hash_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |=> (r_hash == FNV_BASIS) && (r_hcnt == '0))
        else $error("hash not restarted after verdict");

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= ACTIVE_W'(TABLE_DEPTH))
        else $error("active count above table depth");

endmodule

>>> tb/packet_dedupe_filter_tb.sv
// ----------------------------------------------------------------------------
// packet_dedupe_filter_tb
// self-checking bench for the duplicate packet filter. a scoreboard class keeps
// its own running hash, flow table and counters, predicts every verdict and
// sweep report from the accepted input beats and compares each result beat
// field by field. directed corner cases come first, then random traffic with
// replayed packets under several ttl settings, with random gaps and stalls on
// both channels
// ----------------------------------------------------------------------------
module packet_dedupe_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdf_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int HBYTES      = 64;
    localparam int MAX_PKT     = 72;
    localparam int POOL        = 8;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 240;
    localparam int SETTLE      = 60;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        logic                kind;
        logic                dup;
        logic [HASH_W-1:0]   hash;
        logic [CNT_W-1:0]    fwd;
        logic [CNT_W-1:0]    drop;
        logic [ACTIVE_W-1:0] active;
    } t_flow_result;

    class filter_tracker;
        logic [TTL_W-1:0]  ttl_ms;
        logic [HASH_W-1:0] run_hash;
        int                hashed;
        bit                live [DEPTH];
        logic [HASH_W-1:0] slot_hash [DEPTH];
        logic [TIME_W-1:0] slot_time [DEPTH];
        logic [CNT_W-1:0]  fwd_total;
        logic [CNT_W-1:0]  drop_total;
        t_flow_result      results_due [$];
        int unsigned       errors;

        function new();
            ttl_ms     = TTL_W'(TTL_MS_RESET);
            run_hash   = FNV_BASIS;
            hashed     = 0;
            fwd_total  = '0;
            drop_total = '0;
            errors     = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        task mismatch(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        function void take_beat(logic cmd, logic [7:0] data, logic last,
                                logic [TIME_W-1:0] now);
            t_flow_result      res;
            logic [63:0]       ttl_us;
            logic [63:0]       now64;
            logic [63:0]       age_ms;
            logic [HASH_W-1:0] h;
            int                idx;
            int                active;
            int                i;
            logic              dup;
            ttl_us = 64'(ttl_ms) * 64'd1000;
            now64  = 64'(now);
            res    = '{default: '0};
            if (cmd == CMD_SWEEP) begin
                active = 0;
                for (i = 0; i < DEPTH; i++) begin
                    if (live[i]) begin
                        if (now64 >= ttl_us && 64'(slot_time[i]) < now64 - ttl_us)
                            live[i] = 1'b0;
                        else
                            active++;
                    end
                end
                res.kind   = KIND_SWEEP;
                res.fwd    = fwd_total;
                res.drop   = drop_total;
                res.active = ACTIVE_W'(active);
                results_due.push_back(res);
                return;
            end
            if (hashed < HBYTES) begin
                run_hash = (run_hash ^ {24'd0, data}) * FNV_PRIME;
                hashed++;
            end
            if (!last)
                return;
            h   = run_hash;
            idx = int'(h % DEPTH);
            dup = 1'b0;
            if (live[idx] && slot_hash[idx] == h) begin
                age_ms = '0;
                if (now64 > 64'(slot_time[idx]))
                    age_ms = (now64 - 64'(slot_time[idx])) / 64'd1000;
                dup = (age_ms < 64'(ttl_ms));
            end
            if (dup) begin
                if (drop_total != '1) drop_total++;
            end else begin
                slot_hash[idx] = h;
                slot_time[idx] = now;
                live[idx]      = 1'b1;
                if (fwd_total != '1) fwd_total++;
            end
            run_hash   = FNV_BASIS;
            hashed     = 0;
            res.kind   = KIND_VERDICT;
            res.dup    = dup;
            res.hash   = h;
            res.fwd    = fwd_total;
            res.drop   = drop_total;
            results_due.push_back(res);
        endfunction

        task check_beat(t_flow_result got);
            t_flow_result want;
            if (results_due.size() == 0) begin
                mismatch($sformatf("result beat with nothing expected, kind %0b hash %h",
                                   got.kind, got.hash));
                return;
            end
            want = results_due.pop_front();
            if (got.kind !== want.kind)
                mismatch($sformatf("result_kind %0b, expected %0b", got.kind, want.kind));
            if (got.dup !== want.dup)
                mismatch($sformatf("is_duplicate %0b, expected %0b (hash %h)",
                                   got.dup, want.dup, want.hash));
            if (got.hash !== want.hash)
                mismatch($sformatf("packet_hash %h, expected %h", got.hash, want.hash));
            if (got.fwd !== want.fwd)
                mismatch($sformatf("forwarded_count %0d, expected %0d", got.fwd, want.fwd));
            if (got.drop !== want.drop)
                mismatch($sformatf("dropped_count %0d, expected %0d", got.drop, want.drop));
            if (got.active !== want.active)
                mismatch($sformatf("active_flows %0d, expected %0d", got.active, want.active));
        endtask
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [TTL_W-1:0]    i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic                i_command   = CMD_BYTE;
    logic [7:0]          i_data_byte = '0;
    logic                i_last_byte = 1'b0;
    logic [TIME_W-1:0]   i_now_us    = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_result_kind;
    logic                o_is_duplicate;
    logic [HASH_W-1:0]   o_packet_hash;
    logic [CNT_W-1:0]    o_forwarded_count;
    logic [CNT_W-1:0]    o_dropped_count;
    logic [ACTIVE_W-1:0] o_active_flows;

    filter_tracker tracker = new();
    t_flow_result  seen;
    bit            quiet      = 1'b0;
    int            out_hold   = 0;
    int            out_pick;
    int            beats_sent = 0;
    logic [TIME_W-1:0] now_clock = '0;
    logic [7:0]    recent [POOL][MAX_PKT];
    int            recent_len [POOL];
    int            pool_used = 0;
    logic [7:0]    pkt [MAX_PKT];
    int            pkt_len;

    packet_dedupe_filter #(
        .TABLE_DEPTH (DEPTH),
        .HASH_BYTES  (HBYTES)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .i_now_us          (i_now_us),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_kind     (o_result_kind),
        .o_is_duplicate    (o_is_duplicate),
        .o_packet_hash     (o_packet_hash),
        .o_forwarded_count (o_forwarded_count),
        .o_dropped_count   (o_dropped_count),
        .o_active_flows    (o_active_flows)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (quiet) begin
            i_out_stall <= 1'b0;
            out_hold = 0;
        end else if (out_hold > 0) begin
            out_hold--;
        end else begin
            out_pick = $urandom_range(0, 99);
            if (out_pick < 55) begin
                i_out_stall <= 1'b0;
                out_hold = $urandom_range(0, 8);
            end else if (out_pick < 93) begin
                i_out_stall <= 1'b1;
                out_hold = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                out_hold = $urandom_range(10, 60);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.kind   = o_result_kind;
            seen.dup    = o_is_duplicate;
            seen.hash   = o_packet_hash;
            seen.fwd    = o_forwarded_count;
            seen.drop   = o_dropped_count;
            seen.active = o_active_flows;
            tracker.check_beat(seen);
        end
    end

    task automatic send_beat(input logic cmd, input logic [7:0] data, input logic last,
                             input logic [TIME_W-1:0] now);
        int gap;
        int r;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!quiet) begin
            if (r >= 92)
                gap = $urandom_range(10, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= data;
        i_last_byte <= last;
        i_now_us    <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.take_beat(cmd, data, last, now);
        beats_sent++;
    endtask

    task automatic write_ttl(input logic [TTL_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.ttl_ms = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_results(input int extra);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin
        int p;
        int phase_start;
        int r;
        int k;
        int i;
        int unsigned ttl_span;
        logic [TTL_W-1:0] ttl_val;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, repeats, time going backwards, age equal to ttl
        send_beat(CMD_SWEEP, 8'h00, 1'b0, 48'd0);
        send_beat(CMD_BYTE, 8'h00, 1'b1, 48'd1000);
        send_beat(CMD_BYTE, 8'h00, 1'b1, 48'd2000);
        send_beat(CMD_BYTE, 8'hFF, 1'b1, 48'd3000);
        send_beat(CMD_BYTE, 8'hA5, 1'b0, TIME_MAX);
        send_beat(CMD_BYTE, 8'h5A, 1'b1, 48'd4000);
        send_beat(CMD_BYTE, 8'h12, 1'b0, 48'd0);
        send_beat(CMD_SWEEP, 8'hFF, 1'b1, 48'd4000);
        send_beat(CMD_BYTE, 8'h34, 1'b1, 48'd5000);
        send_beat(CMD_BYTE, 8'hFF, 1'b1, 48'd500);
        send_beat(CMD_BYTE, 8'h00, 1'b1, 48'd5_001_000);
        send_beat(CMD_SWEEP, 8'h00, 1'b0, 48'd5_004_500);
        send_beat(CMD_BYTE, 8'h00, 1'b1, 48'd5_004_999);
        send_beat(CMD_SWEEP, 8'h00, 1'b0, TIME_MAX);
        send_beat(CMD_BYTE, 8'h00, 1'b1, TIME_MAX);
        wait_results(SETTLE);

        for (p = 0; p < PHASES; p++) begin
            quiet = (p == 3);
            unique case (p)
                0: ttl_val = 16'd1;
                1: ttl_val = 16'd0;
                2: ttl_val = 16'hFFFF;
                3: ttl_val = TTL_W'($urandom_range(2, 40));
                4: ttl_val = TTL_W'($urandom_range(1, 65535));
                default: ttl_val = TTL_W'(TTL_MS_RESET);
            endcase
            write_ttl(ttl_val);
            if (p == 0)
                now_clock = TIME_W'($urandom_range(0, 1_000_000));
            else if (p == 2)
                now_clock = TIME_MAX - TIME_W'($urandom_range(0, 100_000_000));
            else
                now_clock = TIME_W'({$urandom, $urandom});
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                ttl_span = 32'(tracker.ttl_ms) * 1000 + 5000;
                r = $urandom_range(0, 99);
                if (r < 70)
                    now_clock += TIME_W'($urandom_range(0, 2000));
                else if (r < 90)
                    now_clock += TIME_W'($urandom_range(0, ttl_span));
                else if (r < 97)
                    now_clock += TIME_W'($urandom_range(ttl_span, 2 * ttl_span));
                else
                    now_clock -= TIME_W'($urandom_range(0, 5000));

                if ($urandom_range(0, 13) == 0) begin
                    send_beat(CMD_SWEEP, 8'($urandom), 1'($urandom), now_clock);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 45 && pool_used > 0) begin
                        // replay a recent packet, past the hashed bytes the tail may differ
                        k = $urandom_range(0, pool_used - 1);
                        pkt_len = recent_len[k];
                        for (i = 0; i < pkt_len; i++)
                            pkt[i] = (i >= HBYTES && $urandom_range(0, 1) == 1) ?
                                     8'($urandom) : recent[k][i];
                    end else begin
                        r = $urandom_range(0, 99);
                        if (r < 85)
                            pkt_len = $urandom_range(1, 8);
                        else if (r < 97)
                            pkt_len = $urandom_range(9, 24);
                        else
                            pkt_len = $urandom_range(60, MAX_PKT);
                        for (i = 0; i < pkt_len; i++)
                            pkt[i] = 8'($urandom);
                        if (pool_used < POOL) begin
                            k = pool_used;
                            pool_used++;
                        end else begin
                            k = $urandom_range(0, POOL - 1);
                        end
                        recent_len[k] = pkt_len;
                        for (i = 0; i < pkt_len; i++)
                            recent[k][i] = pkt[i];
                    end
                    for (i = 0; i < pkt_len; i++) begin
                        if (i > 0 && $urandom_range(0, 49) == 0)
                            send_beat(CMD_SWEEP, 8'($urandom), 1'($urandom), now_clock);
                        send_beat(CMD_BYTE, pkt[i], i == pkt_len - 1,
                                  (i == pkt_len - 1) ? now_clock : TIME_W'({$urandom, $urandom}));
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    wait_results(0);
            end
            wait_results(SETTLE);
        end

        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> packet_dedupe_filter.f
rtl/core/pdf_pkg.sv
rtl/core/pdf_ctrl.sv
rtl/core/pdf_dp.sv
rtl/core/packet_dedupe_filter.sv
tb/packet_dedupe_filter_tb.sv
